// ----- rtl/core/gvf_pkg.sv -----
// ----------------------------------------------------------------------------
// gvf_pkg
// Shared types and constants of the GARCH(1,1) volatility filter core.
// ----------------------------------------------------------------------------
package gvf_pkg;

    // parameter defaults
    localparam int FRAC_BITS_DEF    = 16;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // field widths
    localparam int RES_W     = 32;
    localparam int RVOL_W    = 31;
    localparam int SIGMA_W   = 32;
    localparam int OMEGA_W   = 32;
    localparam int GAIN_W    = 16;
    localparam int GAIN_BITS = 16;
    localparam int MUL_W     = 32;
    localparam int WIDE_W    = 64;

    // divide / square root unit sizing
    localparam int DEN_W      = GAIN_BITS + 1;
    localparam int QUO_W      = OMEGA_W + GAIN_BITS;
    localparam int DIV_STEPS  = QUO_W;
    localparam int ROOT_STEPS = WIDE_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MEAN_RETURN = 4'd0,
        CFG_OMEGA_TERM  = 4'd1,
        CFG_ALPHA_GAIN  = 4'd2,
        CFG_BETA_GAIN   = 4'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RES,
        ST_SQ_SIG,
        ST_AL_LO,
        ST_AL_HI,
        ST_BE_LO,
        ST_BE_HI,
        ST_BE_ACC,
        ST_SUM,
        ST_DIV,
        ST_ROOT,
        ST_DONE
    } gvf_state_t;

    // command into the shift-subtract unit
    typedef struct packed {
        logic start;
        logic root_mode;
    } ssu_cmd_t;

    // status out of the shift-subtract unit
    typedef struct packed {
        logic busy;
        logic done;
    } ssu_stat_t;

endpackage

// ----- rtl/core/garch_volatility_filter_core.sv -----
// ----------------------------------------------------------------------------
// garch_volatility_filter_core
// Streaming GARCH(1,1) conditional volatility filter in fixed point.
//
//   channel  direction  handshake             beat contents
//   in       sink       in_valid / in_ready   sample_return, series_start
//   out      source     out_valid / out_ready residual, realized_vol,
//                                             conditional_vol, overflow_flag
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A normal beat runs eight sequencer steps around the shared 32x32 multiplier,
// then the shift-subtract square root unless the variance saturates.
// A series-start beat runs a division, then the root unless the quotient
// saturates; with alpha+beta not below one it goes straight to the done step.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next beat may be taken while it is stalled.
// cfg_ready is always high. Reset restores register defaults and clears state.
// ----------------------------------------------------------------------------
module garch_volatility_filter_core #(
    parameter int FRAC_BITS    = gvf_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_WIDTH = gvf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample_return,
    input  logic                                series_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gvf_pkg::RES_W-1:0]    residual,
    output logic [gvf_pkg::RVOL_W-1:0]          realized_vol,
    output logic [gvf_pkg::SIGMA_W-1:0]         conditional_vol,
    output logic                                overflow_flag,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gvf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gvf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import gvf_pkg::*;

    localparam int DIFF_W = ((SAMPLE_WIDTH > RES_W) ? SAMPLE_WIDTH : RES_W) + 1;
    localparam int ACC_W  = WIDE_W + GAIN_W;
    localparam logic [RES_W-1:0]   RES_MAX_C  = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0]   RES_MIN_C  = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RVOL_W-1:0]  RVOL_MAX_C = {RVOL_W{1'b1}};
    localparam logic [SIGMA_W-1:0] SIGMA_MAX_C = {SIGMA_W{1'b1}};
    localparam logic [DEN_W-1:0]   GAIN_ONE_C = {1'b1, {GAIN_BITS{1'b0}}};

    // gain product back to Q.FRAC_BITS, low 48 bits all ones above 64 bits
    function automatic logic [WIDE_W-1:0] gain_scale(input logic [ACC_W-1:0] acc);
        logic [WIDE_W-1:0] v;
        begin
            if (|acc[ACC_W-1:WIDE_W])
                v = {{GAIN_BITS{1'b0}}, {(WIDE_W-GAIN_BITS){1'b1}}};
            else
                v = {{GAIN_BITS{1'b0}}, acc[WIDE_W-1:GAIN_BITS]};
            return v;
        end
    endfunction

    // configuration registers
    logic [RES_W-1:0]   mu_reg;
    logic [OMEGA_W-1:0] omega_reg;
    logic [GAIN_W-1:0]  alpha_reg;
    logic [GAIN_W-1:0]  beta_reg;

    // recursion state
    logic [RES_W-1:0]   last_res_reg, last_res_next;
    logic [SIGMA_W-1:0] last_sig_reg, last_sig_next;

    // sequencer
    gvf_state_t state_reg, state_next;

    // per-beat working registers
    logic [RES_W-1:0]   cur_res_reg, cur_res_next;
    logic [RVOL_W-1:0]  cur_mag_reg, cur_mag_next;
    logic               flag_reg, flag_next;
    logic [SIGMA_W-1:0] sigma_reg, sigma_next;
    logic [WIDE_W-1:0]  r2_reg, r2_next;
    logic [WIDE_W-1:0]  s2_reg, s2_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [WIDE_W-1:0]  va_reg, va_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [RES_W-1:0]   residual_reg, residual_next;
    logic [RVOL_W-1:0]  rvol_reg, rvol_next;
    logic [SIGMA_W-1:0] cvol_reg, cvol_next;
    logic               oflag_reg, oflag_next;

    // combinational datapath
    logic               accept;
    logic               out_free;
    logic [DIFF_W-1:0]  diff_full;
    logic [DIFF_W-RES_W:0] diff_hi;
    logic               res_ovf;
    logic [RES_W-1:0]   res_sat;
    logic [RES_W-1:0]   res_neg;
    logic               res_is_min;
    logic [RVOL_W-1:0]  mag;
    logic [DEN_W-1:0]   gain_sum;
    logic               unstable;
    logic [DEN_W-1:0]   den;
    logic [RES_W-1:0]   pm;
    logic [ACC_W-1:0]   prod_hi_sh;
    logic [WIDE_W-1:0]  gain_term;
    logic [WIDE_W:0]    omega_sum;
    logic [WIDE_W:0]    beta_sum;
    logic [WIDE_W-1:0]  v_sum;
    logic               v_ovf;
    logic [WIDE_W-1:0]  v_quo;
    logic               q_ovf;

    // unit connections
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [2*MUL_W-1:0]  mul_p;
    ssu_cmd_t            ssu_cmd;
    ssu_stat_t           ssu_stat;
    logic [WIDE_W-1:0]   ssu_operand;
    logic [QUO_W-1:0]    ssu_result;

    gvf_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    gvf_shift_sub u_shift_sub (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ssu_cmd),
        .operand (ssu_operand),
        .divisor (den),
        .stat    (ssu_stat),
        .result  (ssu_result)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // residual, clamp and magnitude
    always_comb
    begin
        diff_full = {{(DIFF_W-SAMPLE_WIDTH){sample_return[SAMPLE_WIDTH-1]}}, sample_return}
                  - {{(DIFF_W-RES_W){mu_reg[RES_W-1]}}, mu_reg};
        diff_hi    = diff_full[DIFF_W-1:RES_W-1];
        res_ovf    = !((&diff_hi) || !(|diff_hi));
        if (res_ovf)
            res_sat = diff_full[DIFF_W-1] ? RES_MIN_C : RES_MAX_C;
        else
            res_sat = diff_full[RES_W-1:0];
        res_neg    = '0 - res_sat;
        res_is_min = (res_sat == RES_MIN_C);
        if (res_is_min)
            mag = RVOL_MAX_C;
        else if (res_sat[RES_W-1])
            mag = res_neg[RVOL_W-1:0];
        else
            mag = res_sat[RVOL_W-1:0];
    end

    // gain sum, long-run denominator and previous residual magnitude
    always_comb
    begin
        gain_sum = {1'b0, alpha_reg} + {1'b0, beta_reg};
        unstable = gain_sum[DEN_W-1];
        den      = GAIN_ONE_C - gain_sum;
        pm       = last_res_reg[RES_W-1] ? ('0 - last_res_reg) : last_res_reg;
    end

    // variance sums and the overflow checks ahead of the root
    always_comb
    begin
        prod_hi_sh = {mul_p[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}};
        gain_term  = gain_scale(acc_reg);
        omega_sum  = {{(WIDE_W-OMEGA_W+1){1'b0}}, omega_reg} + {1'b0, gain_term};
        beta_sum   = {1'b0, va_reg} + {1'b0, gain_term};
        v_sum      = beta_sum[WIDE_W] ? {WIDE_W{1'b1}} : beta_sum[WIDE_W-1:0];
        v_ovf      = |(v_sum >> (WIDE_W - FRAC_BITS));
        v_quo      = {{(WIDE_W-QUO_W){1'b0}}, ssu_result};
        q_ovf      = |(v_quo >> (WIDE_W - FRAC_BITS));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!series_start)
                        state_next = ST_SQ_RES;
                    else if (unstable)
                        state_next = ST_DONE;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_SQ_RES: state_next = ST_SQ_SIG;
            ST_SQ_SIG: state_next = ST_AL_LO;
            ST_AL_LO:  state_next = ST_AL_HI;
            ST_AL_HI:  state_next = ST_BE_LO;
            ST_BE_LO:  state_next = ST_BE_HI;
            ST_BE_HI:  state_next = ST_BE_ACC;
            ST_BE_ACC: state_next = ST_SUM;
            ST_SUM:    state_next = v_ovf ? ST_DONE : ST_ROOT;
            ST_DIV:
            begin
                if (ssu_stat.done)
                    state_next = q_ovf ? ST_DONE : ST_ROOT;
            end
            ST_ROOT:
            begin
                if (ssu_stat.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and register updates
    always_comb
    begin
        mul_a          = '0;
        mul_b          = '0;
        ssu_cmd        = '0;
        ssu_operand    = {omega_reg, {(WIDE_W-OMEGA_W){1'b0}}};
        cur_res_next   = cur_res_reg;
        cur_mag_next   = cur_mag_reg;
        flag_next      = flag_reg;
        sigma_next     = sigma_reg;
        r2_next        = r2_reg;
        s2_next        = s2_reg;
        acc_next       = acc_reg;
        va_next        = va_reg;
        last_res_next  = last_res_reg;
        last_sig_next  = last_sig_reg;
        residual_next  = residual_reg;
        rvol_next      = rvol_reg;
        cvol_next      = cvol_reg;
        oflag_next     = oflag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_res_next = res_sat;
                    cur_mag_next = mag;
                    flag_next    = res_ovf || res_is_min || unstable;
                    sigma_next   = SIGMA_MAX_C;
                    ssu_cmd.start     = series_start && !unstable;
                    ssu_cmd.root_mode = 1'b0;
                end
            end
            ST_SQ_RES:
            begin
                mul_a = pm;
                mul_b = pm;
            end
            ST_SQ_SIG:
            begin
                mul_a   = last_sig_reg;
                mul_b   = last_sig_reg;
                r2_next = mul_p >> FRAC_BITS;
            end
            ST_AL_LO:
            begin
                mul_a   = {{(MUL_W-GAIN_W){1'b0}}, alpha_reg};
                mul_b   = r2_reg[MUL_W-1:0];
                s2_next = mul_p >> FRAC_BITS;
            end
            ST_AL_HI:
            begin
                mul_a    = {{(MUL_W-GAIN_W){1'b0}}, alpha_reg};
                mul_b    = r2_reg[WIDE_W-1:MUL_W];
                acc_next = {{(ACC_W-WIDE_W){1'b0}}, mul_p};
            end
            ST_BE_LO:
            begin
                mul_a    = {{(MUL_W-GAIN_W){1'b0}}, beta_reg};
                mul_b    = s2_reg[MUL_W-1:0];
                acc_next = acc_reg + prod_hi_sh;
            end
            ST_BE_HI:
            begin
                // alpha term is complete: fold it into omega
                mul_a     = {{(MUL_W-GAIN_W){1'b0}}, beta_reg};
                mul_b     = s2_reg[WIDE_W-1:MUL_W];
                acc_next  = {{(ACC_W-WIDE_W){1'b0}}, mul_p};
                va_next   = omega_sum[WIDE_W] ? {WIDE_W{1'b1}} : omega_sum[WIDE_W-1:0];
                flag_next = flag_reg || (|acc_reg[ACC_W-1:WIDE_W]) || omega_sum[WIDE_W];
            end
            ST_BE_ACC:
            begin
                acc_next = acc_reg + prod_hi_sh;
            end
            ST_SUM:
            begin
                // beta term added, then the root or saturation
                flag_next = flag_reg || (|acc_reg[ACC_W-1:WIDE_W]) || beta_sum[WIDE_W]
                          || v_ovf;
                sigma_next        = SIGMA_MAX_C;
                ssu_cmd.start     = !v_ovf;
                ssu_cmd.root_mode = 1'b1;
                ssu_operand       = v_sum << FRAC_BITS;
            end
            ST_DIV:
            begin
                if (ssu_stat.done)
                begin
                    flag_next         = flag_reg || q_ovf;
                    sigma_next        = SIGMA_MAX_C;
                    ssu_cmd.start     = !q_ovf;
                    ssu_cmd.root_mode = 1'b1;
                    ssu_operand       = v_quo << FRAC_BITS;
                end
            end
            ST_ROOT:
            begin
                if (ssu_stat.done)
                    sigma_next = ssu_result[SIGMA_W-1:0];
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    residual_next  = cur_res_reg;
                    rvol_next      = cur_mag_reg;
                    cvol_next      = sigma_reg;
                    oflag_next     = flag_reg;
                    out_valid_next = 1'b1;
                    last_res_next  = cur_res_reg;
                    last_sig_next  = sigma_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    // control, configuration and recursion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_res_reg  <= '0;
            last_sig_reg  <= '0;
            mu_reg        <= '0;
            omega_reg     <= OMEGA_W'(65536);
            alpha_reg     <= '0;
            beta_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            last_res_reg  <= last_res_next;
            last_sig_reg  <= last_sig_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_MEAN_RETURN: mu_reg    <= cfg_data[RES_W-1:0];
                    CFG_OMEGA_TERM:  omega_reg <= cfg_data[OMEGA_W-1:0];
                    CFG_ALPHA_GAIN:  alpha_reg <= cfg_data[GAIN_W-1:0];
                    CFG_BETA_GAIN:   beta_reg  <= cfg_data[GAIN_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        cur_res_reg  <= cur_res_next;
        cur_mag_reg  <= cur_mag_next;
        flag_reg     <= flag_next;
        sigma_reg    <= sigma_next;
        r2_reg       <= r2_next;
        s2_reg       <= s2_next;
        acc_reg      <= acc_next;
        va_reg       <= va_next;
        residual_reg <= residual_next;
        rvol_reg     <= rvol_next;
        cvol_reg     <= cvol_next;
        oflag_reg    <= oflag_next;
    end

    assign out_valid       = out_valid_reg;
    assign residual        = residual_reg;
    assign realized_vol    = rvol_reg;
    assign conditional_vol = cvol_reg;
    assign overflow_flag   = oflag_reg;

    // an accepted beat always starts the sequencer
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("sequencer stayed idle after an input beat");

    // the shift-subtract unit is never restarted mid-operation
    a_ssu_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ssu_cmd.start |-> !ssu_stat.busy)
        else $error("shift-subtract unit restarted while busy");

    // a new result appears only out of the done step
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("output loaded outside the done step");

    // gains not below one always raise the flag
    a_unstable_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && unstable |-> oflag_reg)
        else $error("overflow flag missing with unstable gains");

endmodule

// ----- rtl/core/gvf_mul.sv -----
// ----------------------------------------------------------------------------
// gvf_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module gvf_mul (
    input  logic                            clk,
    input  logic [gvf_pkg::MUL_W-1:0]       a,
    input  logic [gvf_pkg::MUL_W-1:0]       b,
    output logic [2*gvf_pkg::MUL_W-1:0]     p
);
    import gvf_pkg::*;

    logic [2*MUL_W-1:0] p_reg;
    logic [2*MUL_W-1:0] p_next;

    // full-width product
    assign p_next = {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};

    // product register
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- rtl/core/gvf_shift_sub.sv -----
// ----------------------------------------------------------------------------
// gvf_shift_sub
// Shared shift-subtract unit: restoring division one quotient bit per cycle,
// or digit-by-digit square root one root bit per cycle.
// ----------------------------------------------------------------------------
module gvf_shift_sub (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gvf_pkg::ssu_cmd_t             cmd,
    input  logic [gvf_pkg::WIDE_W-1:0]    operand,
    input  logic [gvf_pkg::DEN_W-1:0]     divisor,
    output gvf_pkg::ssu_stat_t            stat,
    output logic [gvf_pkg::QUO_W-1:0]     result
);
    import gvf_pkg::*;

    localparam int REM_W = SIGMA_W + 3;

    logic [WIDE_W-1:0] opnd_reg, opnd_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  res_reg, res_next;
    logic [DEN_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              root_reg, root_next;

    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              ge;
    logic              last_step;

    // one step: bring in the next operand bits and try the subtract
    always_comb
    begin
        if (root_reg)
        begin
            shifted = {rem_reg[REM_W-3:0], opnd_reg[WIDE_W-1 -: 2]};
            trial   = {1'b0, res_reg[SIGMA_W-1:0], 2'b01};
        end
        else
        begin
            shifted = {rem_reg[REM_W-2:0], opnd_reg[WIDE_W-1]};
            trial   = {{(REM_W-DEN_W){1'b0}}, dvs_reg};
        end
        diff      = {1'b0, shifted} - {1'b0, trial};
        ge        = ~diff[REM_W];
        last_step = root_reg ? (cnt_reg == STEP_W'(ROOT_STEPS - 1))
                             : (cnt_reg == STEP_W'(DIV_STEPS - 1));
    end

    // next values
    always_comb
    begin
        opnd_next = opnd_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        root_next = root_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            opnd_next = operand;
            rem_next  = '0;
            res_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            root_next = cmd.root_mode;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[REM_W-1:0] : shifted;
            res_next  = {res_reg[QUO_W-2:0], ge};
            opnd_next = root_reg ? {opnd_reg[WIDE_W-3:0], 2'b00}
                                 : {opnd_reg[WIDE_W-2:0], 1'b0};
            cnt_next  = cnt_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            root_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            root_reg <= root_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        dvs_reg  <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule
